// ----- src/fqks_pkg.sv -----
package fqks_pkg;

    // fixed field widths of the transaction ports
    localparam int KEY_W  = 64;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;
    localparam int POS_W  = 5;

    // operation requested by an input transaction
    typedef enum logic [MODE_W-1:0] {
        MODE_ENQ    = 2'd0,
        MODE_DEQ    = 2'd1,
        MODE_SEARCH = 2'd2
    } mode_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // datapath to controller status
    typedef struct packed {
        mode_t mode;
        logic  full;
        logic  empty;
        logic  hit;
        logic  last;
    } dp_stat_t;

    // controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    push;
        logic    read_head;
        logic    scan_first;
        logic    scan_next;
        logic    pop;
        logic    post;
        status_t post_status;
        logic    give_removed;
        logic    give_pos;
    } dp_cmd_t;

endpackage

// ----- src/fqks_ram.sv -----
module fqks_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/fqks_ctrl.sv -----
module fqks_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  fqks_pkg::dp_stat_t stat,
    output fqks_pkg::dp_cmd_t  cmd
);

    import fqks_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DEQ  = 4'b0100,
        S_SCAN = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.post_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.mode)
                    MODE_ENQ:
                    begin
                        cmd.post = 1'b1;
                        if (stat.full)
                        begin
                            cmd.post_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                    MODE_DEQ:
                    begin
                        if (stat.empty)
                        begin
                            cmd.post        = 1'b1;
                            cmd.post_status = ST_EMPTY;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            cmd.read_head = 1'b1;
                            state_next    = S_DEQ;
                        end
                    end
                    MODE_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            cmd.post        = 1'b1;
                            cmd.post_status = ST_EMPTY;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            cmd.read_head  = 1'b1;
                            cmd.scan_first = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    default:
                    begin
                        // unused operation code: plain ok result
                        cmd.post   = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DEQ:
            begin
                cmd.post         = 1'b1;
                cmd.give_removed = 1'b1;
                cmd.pop          = 1'b1;
                state_next       = S_IDLE;
            end
            S_SCAN:
            begin
                priority if (stat.hit)
                begin
                    cmd.post     = 1'b1;
                    cmd.give_pos = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.last)
                begin
                    cmd.post        = 1'b1;
                    cmd.post_status = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // a posted result always ends the transaction
    a_post_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |=> state_reg == S_IDLE)
        else $error("result posted without returning to idle");

    // a scan step never coincides with a posted result
    a_scan_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.scan_next && cmd.post))
        else $error("scan step and result in the same cycle");

endmodule

// ----- src/fqks_dp.sv -----
module fqks_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BYTES   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [fqks_pkg::MODE_W-1:0]         mode,
    input  logic [fqks_pkg::KEY_W-1:0]          name_key,
    input  fqks_pkg::dp_cmd_t                   cmd,
    output fqks_pkg::dp_stat_t                  stat,
    output logic                                done,
    output logic [fqks_pkg::STAT_W-1:0]         status,
    output logic [fqks_pkg::KEY_W-1:0]          removed_key,
    output logic [fqks_pkg::POS_W-1:0]          position
);

    import fqks_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int KW = KEY_BYTES * 8;
    localparam logic [AW:0]   DEPTH_S = (AW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    head_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [AW-1:0]    scan_idx_reg;
    logic [AW-1:0]    scan_idx_next;
    mode_t            mode_reg;
    logic [KW-1:0]    key_reg;
    logic             done_reg;
    status_t          status_reg;
    logic [KEY_W-1:0] removed_reg;
    logic [POS_W-1:0] pos_reg;

    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;
    logic [KW-1:0]    rd_data;
    logic [AW-1:0]    scan_off;
    logic [CW-1:0]    scan_cnt;

    // ring slot of an offset from a base, one compare and subtract
    function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                                 input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    // key store
    fqks_ram #(
        .WIDTH (KW),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (wr_addr),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // addresses and scan bookkeeping
    assign scan_off = scan_idx_reg + AW'(1);
    assign scan_cnt = CW'(scan_idx_reg) + CW'(1);
    assign wr_addr  = ring_slot(head_reg, count_reg[AW-1:0]);
    assign rd_en    = cmd.read_head | cmd.scan_next;
    assign rd_addr  = cmd.scan_next ? ring_slot(head_reg, scan_off) : head_reg;

    // status towards the controller
    assign stat.mode  = mode_reg;
    assign stat.full  = (count_reg == DEPTH_C);
    assign stat.empty = (count_reg == '0);
    assign stat.hit   = (rd_data == key_reg);
    assign stat.last  = (scan_cnt == count_reg);

    // queue pointers
    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.pop)
        begin
            head_next  = ring_slot(head_reg, AW'(1));
            count_next = count_reg - CW'(1);
        end
        if (cmd.scan_first)
        begin
            scan_idx_next = '0;
        end
        else if (cmd.scan_next)
        begin
            scan_idx_next = scan_off;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= cmd.post;
        end
    end

    // transaction fields and result registers
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        if (cmd.load)
        begin
            mode_reg <= mode_t'(mode);
            key_reg  <= name_key[KW-1:0];
        end
        if (cmd.post)
        begin
            status_reg  <= cmd.post_status;
            removed_reg <= cmd.give_removed ? KEY_W'(rd_data) : '0;
            pos_reg     <= cmd.give_pos ? POS_W'(scan_cnt) : '0;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign removed_key = removed_reg;
    assign position    = pos_reg;

    // occupancy never exceeds the ring
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond queue depth");

    // a full report leaves the queue full
    a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == ST_FULL |-> count_reg == DEPTH_C)
        else $error("full reported on a queue with room");

endmodule

// ----- src/fifo_queue_with_key_search.sv -----
// channel   | signals                          | handshake
// ----------+----------------------------------+---------------------------
// request   | mode, name_key                   | accepted when start && !busy
// result    | status, removed_key, position    | valid for one cycle on done
//
// enqueue, unused codes and empty/full reports: posted from the exec state, then back to idle
// dequeue: adds the deq state for the registered read of the key store ram
// search: the scan state compares one stored key per cycle until a hit or the last entry
// reset clears head and count; store contents need no clearing
// done pulses once per request; the receiver cannot stall
module fifo_queue_with_key_search #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BYTES   = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [fqks_pkg::MODE_W-1:0] mode,
    input  logic [fqks_pkg::KEY_W-1:0]  name_key,
    output logic                        done,
    output logic [fqks_pkg::STAT_W-1:0] status,
    output logic [fqks_pkg::KEY_W-1:0]  removed_key,
    output logic [fqks_pkg::POS_W-1:0]  position
);

    import fqks_pkg::*;

    dp_stat_t stat;
    dp_cmd_t  cmd;

    // controller
    fqks_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath
    fqks_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode),
        .name_key    (name_key),
        .cmd         (cmd),
        .stat        (stat),
        .done        (done),
        .status      (status),
        .removed_key (removed_key),
        .position    (position)
    );

    // every accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transaction accepted but block not busy");

    // result strobe only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fqks_pkg::*;

    localparam int RING_DEPTH = 16;
    localparam int RANDOM_REQUESTS = 1100;
    localparam int TAIL_CYCLES = 40;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // one request waiting to be driven
    typedef struct {
        logic [MODE_W-1:0] op;
        logic [KEY_W-1:0]  key;
        int unsigned       gap;
        bit                settle;
    } request_t;

    // one expected answer
    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] removed;
        logic [POS_W-1:0] pos;
    } answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [MODE_W-1:0]  mode = '0;
    logic [KEY_W-1:0]   name_key = '0;
    logic               busy;
    logic               done;
    logic [STAT_W-1:0]  status;
    logic [KEY_W-1:0]   removed_key;
    logic [POS_W-1:0]   position;

    request_t           request_q[$];
    answer_t            answer_q[$];
    logic [KEY_W-1:0]   shadow_q[$];
    int unsigned        request_total = 0;
    int unsigned        accepted_total = 0;
    int unsigned        fault_count = 0;

    // predicted queue contents
    logic [KEY_W-1:0]   ring_keys [RING_DEPTH];
    logic [3:0]         ring_head = '0;
    logic [4:0]         ring_fill = '0;

    fifo_queue_with_key_search u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .name_key    (name_key),
        .done        (done),
        .status      (status),
        .removed_key (removed_key),
        .position    (position)
    );

    always #5 clk = ~clk;

    // apply one request to the predicted queue and return its answer
    function automatic answer_t apply_request(logic [MODE_W-1:0] op, logic [KEY_W-1:0] key);
        answer_t    r;
        logic [3:0] idx;
        bit         hit;
        r.status = ST_OK;
        r.removed = '0;
        r.pos = '0;
        hit = 1'b0;
        case (op)
            MODE_ENQ:
            begin
                if (ring_fill == RING_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    idx = ring_head + ring_fill[3:0];
                    ring_keys[idx] = key;
                    ring_fill = ring_fill + 5'd1;
                end
            end
            MODE_DEQ:
            begin
                if (ring_fill == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.removed = ring_keys[ring_head];
                    ring_head = ring_head + 4'd1;
                    ring_fill = ring_fill - 5'd1;
                end
            end
            MODE_SEARCH:
            begin
                if (ring_fill == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    for (int i = 0; i < ring_fill; i++)
                    begin
                        idx = ring_head + 4'(i);
                        if (!hit && ring_keys[idx] == key)
                        begin
                            hit = 1'b1;
                            r.pos = 5'(i + 1);
                        end
                    end
                    if (!hit)
                        r.status = ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // queue a request and track what the queue will hold once it has run
    task automatic add_request(logic [MODE_W-1:0] op, logic [KEY_W-1:0] key,
                               int unsigned gap, bit settle);
        request_t q;
        q.op = op;
        q.key = key;
        q.gap = gap;
        q.settle = settle;
        request_q.push_back(q);
        request_total++;
        if (op == MODE_ENQ && shadow_q.size() < RING_DEPTH)
            shadow_q.push_back(key);
        else if (op == MODE_DEQ && shadow_q.size() > 0)
            void'(shadow_q.pop_front());
    endtask

    // short lower-case name, zero-padded
    function automatic logic [KEY_W-1:0] random_name();
        logic [KEY_W-1:0] k;
        int unsigned      len;
        k = '0;
        len = $urandom_range(1, 8);
        for (int b = 0; b < len; b++)
            k[8*b +: 8] = 8'($urandom_range(97, 122));
        return k;
    endfunction

    // driver: presents requests, holds each until accepted
    always @(posedge clk)
    begin
        bit          fire;
        bit          go;
        request_t    cur;
        bit          loaded;
        int unsigned hold;
        if (!rst_n)
        begin
            start <= 1'b0;
            loaded = 1'b0;
            hold = 0;
        end
        else
        begin
            fire = start && !busy;
            if (!start || fire)
            begin
                go = 1'b0;
                if (!loaded && request_q.size() > 0)
                begin
                    cur = request_q.pop_front();
                    loaded = 1'b1;
                    hold = cur.gap;
                end
                if (loaded)
                begin
                    if (hold > 0)
                        hold--;
                    else if (!cur.settle || (!fire && answer_q.size() == 0))
                        go = 1'b1;
                end
                if (go)
                begin
                    start <= 1'b1;
                    mode <= cur.op;
                    name_key <= cur.key;
                    loaded = 1'b0;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: predicts on every accepted transaction, checks every result
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                answer_q.push_back(apply_request(mode, name_key));
                accepted_total++;
            end
            if (done)
            begin
                if (answer_q.size() == 0)
                begin
                    fault_count++;
                    $display("%0t: result with nothing expected: status %0d key %h pos %0d",
                             $time, status, removed_key, position);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (status !== want.status)
                    begin
                        fault_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                    end
                    if (removed_key !== want.removed)
                    begin
                        fault_count++;
                        $display("%0t: removed_key expected %h actual %h",
                                 $time, want.removed, removed_key);
                    end
                    if (position !== want.pos)
                    begin
                        fault_count++;
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.pos, position);
                    end
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        logic [KEY_W-1:0] fill_keys [RING_DEPTH];
        logic [KEY_W-1:0] key;
        int unsigned      phase;
        int unsigned      idle_style;
        int unsigned      gap;
        int unsigned      r;
        logic [MODE_W-1:0] op;

        // directed: empty cases, an unused code, fill to full, search extremes
        for (int i = 0; i < RING_DEPTH; i++)
            fill_keys[i] = 64'h1 << (4 * i);
        fill_keys[0] = 64'h0;
        fill_keys[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        fill_keys[2] = 64'h5555_5555_5555_5555;
        fill_keys[3] = 64'hAAAA_AAAA_AAAA_AAAA;
        fill_keys[12] = fill_keys[9];
        add_request(MODE_DEQ, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
        add_request(MODE_SEARCH, 64'h0, 3, 1'b0);
        add_request(MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
        for (int i = 0; i < RING_DEPTH; i++)
            add_request(MODE_ENQ, fill_keys[i], $urandom_range(0, 19), 1'b0);
        add_request(MODE_ENQ, 64'h0123_4567_89AB_CDEF, 0, 1'b0);
        add_request(MODE_SEARCH, fill_keys[15], 0, 1'b0);
        add_request(MODE_SEARCH, fill_keys[9], 5, 1'b0);
        add_request(MODE_SEARCH, 64'h0123_4567_89AB_CDEF, 0, 1'b0);
        add_request(MODE_DEQ, 64'h0, 0, 1'b0);
        add_request(MODE_SEARCH, fill_keys[1], 0, 1'b0);

        // random: phases that lean to filling, draining or neither
        phase = 0;
        idle_style = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 60 == 0)
            begin
                phase = $urandom_range(0, 2);
                idle_style = $urandom_range(0, 2);
            end
            r = $urandom_range(0, 99);
            if (r < 2)
                op = MODE_UNUSED;
            else if (phase == 0)
                op = (r < 57) ? MODE_ENQ : (r < 87) ? MODE_SEARCH : MODE_DEQ;
            else if (phase == 1)
                op = (r < 15) ? MODE_ENQ : (r < 45) ? MODE_SEARCH : MODE_DEQ;
            else
                op = (r < 35) ? MODE_ENQ : (r < 68) ? MODE_SEARCH : MODE_DEQ;

            r = $urandom_range(0, 99);
            if (op != MODE_DEQ && shadow_q.size() > 0 && r < 45)
                key = shadow_q[$urandom_range(0, shadow_q.size() - 1)];
            else if (r < 80)
                key = random_name();
            else
                key = {$urandom, $urandom};

            if (idle_style == 0)
                gap = 0;
            else if (idle_style == 1)
                gap = $urandom_range(0, 19);
            else
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;

            add_request(op, key, gap, (n % 250 == 125));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_total < request_total || answer_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("PASS fifo_queue_with_key_search");
        else
            $display("FAIL fifo_queue_with_key_search");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("FAIL fifo_queue_with_key_search");
        $finish;
    end

endmodule
